// ===== rtl/ses_pkg.sv =====
`default_nettype none

package ses_pkg;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_ADVANCE  = 2'd2;
	localparam logic [1:0] OP_NOP      = 2'd3;

	localparam logic [63:0] NEVER_CYCLE = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_CYCLE   = 64'hFFFF_FFFF_FFFF_FFFE;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  slot_id;
		logic [31:0] delta;
		logic [7:0]  handler_code;
	} cmd_t;

	typedef struct packed {
		logic        fired;
		logic [2:0]  fired_slot;
		logic [7:0]  fired_handler;
		logic [63:0] clock_now;
		logic [63:0] next_due;
		logic        last;
	} evt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_STATUS
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic emit;
		logic status;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_req;
		logic fire_mode;
		logic scan_done;
		logic emit_done;
		logic emit_empty;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/ses_controller.sv =====
`default_nettype none

module ses_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire ses_pkg::sts_t sts,
	output ses_pkg::ctl_t      ctl
);
	import ses_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		cmd_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall  = 1'b0;
				ctl.accept = cmd_valid;
				if (cmd_valid) begin
					state_d = sts.scan_req ? ST_SCAN : ST_STATUS;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.fire_mode ? ST_EMIT : ST_STATUS;
				end
			end
			ST_EMIT: begin
				ctl.emit = 1'b1;
				if (sts.emit_done) begin
					state_d = ST_IDLE;
				end else if (sts.emit_empty) begin
					state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				ctl.status = 1'b1;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ses_datapath.sv =====
`default_nettype none

module ses_datapath #(
	parameter int SLOT_NUM = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ses_pkg::ctl_t ctl,
	output ses_pkg::sts_t      sts,
	input  wire ses_pkg::cmd_t cmd,
	input  wire logic          evt_stall,
	output logic               evt_valid,
	output ses_pkg::evt_t      evt
);
	import ses_pkg::*;

	localparam int IW = (SLOT_NUM > 1) ? $clog2(SLOT_NUM) : 1;
	localparam int CW = $clog2(SLOT_NUM + 1);
	localparam logic [CW-1:0] SLOT_END = CW'(SLOT_NUM);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic [63:0] trig_mem [SLOT_NUM];
	logic [7:0]  hdl_mem  [SLOT_NUM];

	logic [63:0]         clock_q;
	logic [63:0]         earliest_q;
	logic [63:0]         min_q;
	logic [SLOT_NUM-1:0] ent_vld_q;
	logic [SLOT_NUM-1:0] due_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       due_cnt_q;
	logic                fire_q;
	logic                evt_valid_q;
	evt_t                evt_q;

	logic                pv_s1;
	logic [IW-1:0]       idx_s1;
	logic                vld_s1;
	logic [63:0]         trig_s1;
	logic [7:0]          hdl_s1;

	logic          slot_ok;
	logic [IW-1:0] slot_idx;
	logic [63:0]   clock_inc;
	logic [64:0]   sum_w;
	logic [63:0]   trig_sat;
	logic [IW-1:0] cnt_idx;
	logic          issue;
	logic [63:0]   trig_cur;
	logic          hit;
	logic [63:0]   min_next;
	logic          scan_done;
	logic          out_free;
	logic          due_hit_s1;
	logic          emit_load;
	logic          emit_hold;
	logic          stat_load;
	logic          do_sched;
	logic          do_cancel;
	logic          do_adv;
	logic          scan_req;

	always_comb begin
		slot_ok   = (32'(cmd.slot_id) < 32'(SLOT_NUM));
		slot_idx  = IW'(cmd.slot_id);
		clock_inc = clock_q + 64'd1;
		// saturate one below never so the slot stays pending
		sum_w     = {1'b0, clock_q} + {33'd0, cmd.delta};
		trig_sat  = (sum_w >= {1'b0, SAT_CYCLE}) ? SAT_CYCLE : sum_w[63:0];
		cnt_idx   = cnt_q[IW-1:0];
		issue     = (cnt_q < SLOT_END);
		trig_cur  = vld_s1 ? trig_s1 : NEVER_CYCLE;
		hit       = ctl.scan && pv_s1 && fire_q && (trig_cur <= clock_q);
		min_next  = (ctl.scan && pv_s1 && !hit && (trig_cur < min_q)) ? trig_cur : min_q;
		scan_done = ctl.scan && !issue && pv_s1;
		out_free  = !evt_valid_q || !evt_stall;
		due_hit_s1 = pv_s1 && due_q[idx_s1];
		emit_load = ctl.emit && due_hit_s1 && out_free;
		emit_hold = due_hit_s1 && !out_free;
		stat_load = ctl.status && out_free;

		do_sched  = 1'b0;
		do_cancel = 1'b0;
		do_adv    = 1'b0;
		scan_req  = 1'b0;
		case (cmd.operation)
			OP_SCHEDULE: begin
				do_sched = slot_ok;
				scan_req = slot_ok;
			end
			OP_CANCEL: begin
				do_cancel = slot_ok;
				scan_req  = slot_ok;
			end
			OP_ADVANCE: begin
				do_adv   = 1'b1;
				scan_req = (clock_inc >= earliest_q);
			end
			OP_NOP: begin
				scan_req = 1'b0;
			end
			default: begin
				scan_req = 1'b0;
			end
		endcase
	end

	always_comb begin
		sts.scan_req   = scan_req;
		sts.fire_mode  = fire_q;
		sts.scan_done  = scan_done;
		sts.emit_done  = emit_load && (due_cnt_q == CNT_ONE);
		sts.emit_empty = ctl.emit && (due_cnt_q == '0);
		sts.out_free   = out_free;
	end

	// slot stores
	always_ff @(posedge clk) begin
		if (ctl.accept && do_sched) begin
			trig_mem[slot_idx] <= trig_sat;
		end else if (hit) begin
			trig_mem[idx_s1] <= NEVER_CYCLE;
		end
		if (ctl.scan && issue) begin
			trig_s1 <= trig_mem[cnt_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept && do_sched) begin
			hdl_mem[slot_idx] <= cmd.handler_code;
		end
		if (ctl.emit && !emit_hold && issue) begin
			hdl_s1 <= hdl_mem[cnt_idx];
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.scan || (ctl.emit && !emit_hold)) && issue) begin
			idx_s1 <= cnt_idx;
			vld_s1 <= ent_vld_q[cnt_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			earliest_q  <= NEVER_CYCLE;
			min_q       <= NEVER_CYCLE;
			ent_vld_q   <= '0;
			due_q       <= '0;
			cnt_q       <= '0;
			due_cnt_q   <= '0;
			fire_q      <= 1'b0;
			pv_s1       <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				cnt_q     <= '0;
				pv_s1     <= 1'b0;
				min_q     <= NEVER_CYCLE;
				due_q     <= '0;
				due_cnt_q <= '0;
				fire_q    <= do_adv;
				if (do_adv) begin
					clock_q <= clock_inc;
				end
				if (do_sched) begin
					ent_vld_q[slot_idx] <= 1'b1;
				end
				if (do_cancel) begin
					ent_vld_q[slot_idx] <= 1'b0;
				end
			end

			if (ctl.scan) begin
				min_q <= min_next;
				if (issue) begin
					cnt_q <= cnt_q + CNT_ONE;
					pv_s1 <= 1'b1;
				end else begin
					pv_s1 <= 1'b0;
				end
				if (hit) begin
					due_q[idx_s1] <= 1'b1;
					due_cnt_q     <= due_cnt_q + CNT_ONE;
				end
				// rewind the walk for the firing pass
				if (scan_done) begin
					earliest_q <= min_next;
					cnt_q      <= '0;
				end
			end

			if (ctl.emit && !emit_hold) begin
				if (issue) begin
					cnt_q <= cnt_q + CNT_ONE;
					pv_s1 <= 1'b1;
				end else begin
					pv_s1 <= 1'b0;
				end
			end
			if (emit_load) begin
				due_cnt_q <= due_cnt_q - CNT_ONE;
			end

			if (emit_load || stat_load) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			evt_q.fired         <= 1'b1;
			evt_q.fired_slot    <= 3'(idx_s1);
			evt_q.fired_handler <= vld_s1 ? hdl_s1 : 8'd0;
			evt_q.clock_now     <= clock_q;
			evt_q.next_due      <= earliest_q;
			evt_q.last          <= (due_cnt_q == CNT_ONE);
		end else if (stat_load) begin
			evt_q.fired         <= 1'b0;
			evt_q.fired_slot    <= 3'd0;
			evt_q.fired_handler <= 8'd0;
			evt_q.clock_now     <= clock_q;
			evt_q.next_due      <= earliest_q;
			evt_q.last          <= 1'b1;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> (due_cnt_q != '0))
		else $error("fired transfer with no due slot left");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOT_END)
		else $error("slot walk ran past the last slot");

	a_emit_fired: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (evt_valid && evt.fired))
		else $error("fired slot not presented on the result channel");

	a_adv_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.accept && (cmd.operation == OP_ADVANCE)) |=> (clock_q == $past(clock_inc)))
		else $error("advance did not step the cycle clock");

endmodule

`default_nettype wire

// ===== rtl/slot_event_scheduler.sv =====
`default_nettype none

// Channel   Direction  Payload         Handshake
// cmd       in         ses_pkg::cmd_t  cmd_valid / cmd_stall
// evt       out        ses_pkg::evt_t  evt_valid / evt_stall
//
// Schedule and cancel of a slot in range: accept, slot scan, status result.
// An advance that reaches no trigger goes from accept straight to the status
// result. An advance that fires runs the trigger scan, then the handler walk,
// each reading one slot a cycle from its store; the walk pauses on a stall.
// Reset clears clock, cached earliest trigger and per-slot valid bits at once;
// there is no clearing pass. A stalled result holds in the output register,
// and the next command is taken as soon as the last result is registered.
module slot_event_scheduler #(
	parameter int SLOT_NUM = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire ses_pkg::cmd_t cmd,
	output logic               evt_valid,
	input  wire logic          evt_stall,
	output ses_pkg::evt_t      evt
);
	import ses_pkg::*;

	ctl_t ctl;
	sts_t sts;

	ses_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	ses_datapath #(
		.SLOT_NUM (SLOT_NUM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.evt_stall (evt_stall),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

endmodule

`default_nettype wire

// ===== verif/slot_event_scheduler_checker.sv =====
`timescale 1ns / 1ps

module slot_event_scheduler_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire logic          cmd_stall,
	input  wire ses_pkg::cmd_t cmd,
	input  wire logic          evt_valid,
	input  wire logic          evt_stall,
	input  wire ses_pkg::evt_t evt,
	output int                 fail_count,
	output int                 outstanding,
	output int                 cmds_seen,
	output int                 evts_seen,
	output int                 fires_seen
);
	import ses_pkg::*;

	localparam int SLOTS = 8;

	logic [63:0] tick;
	logic [63:0] arm_at [SLOTS];
	logic [7:0]  arm_code [SLOTS];
	logic [63:0] soonest;

	evt_t expected_evts [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
		cmds_seen   = 0;
		evts_seen   = 0;
		fires_seen  = 0;
	end

	function automatic logic [63:0] earliest_armed();
		logic [63:0] best;
		best = NEVER_CYCLE;
		for (int i = 0; i < SLOTS; i++) begin
			if (arm_at[i] < best)
				best = arm_at[i];
		end
		return best;
	endfunction

	task automatic queue_result(input logic f, input logic [2:0] s, input logic [7:0] h,
			input logic l);
		evt_t e;
		e.fired         = f;
		e.fired_slot    = s;
		e.fired_handler = h;
		e.clock_now     = tick;
		e.next_due      = soonest;
		e.last          = l;
		expected_evts.push_back(e);
	endtask

	// Work out every event one command causes and queue them in order
	task automatic compute_events(input cmd_t c);
		logic [SLOTS-1:0] hit;
		int n;
		int k;
		n = 0;
		case (c.operation)
			OP_SCHEDULE: begin
				if (int'(c.slot_id) < SLOTS) begin
					// saturate one below never so the slot stays armed
					if (tick >= SAT_CYCLE || {32'd0, c.delta} > SAT_CYCLE - tick)
						arm_at[c.slot_id] = SAT_CYCLE;
					else
						arm_at[c.slot_id] = tick + {32'd0, c.delta};
					arm_code[c.slot_id] = c.handler_code;
					soonest = earliest_armed();
				end
			end
			OP_CANCEL: begin
				if (int'(c.slot_id) < SLOTS) begin
					arm_at[c.slot_id]   = NEVER_CYCLE;
					arm_code[c.slot_id] = 8'd0;
					soonest = earliest_armed();
				end
			end
			OP_ADVANCE: begin
				tick = tick + 64'd1;
				if (tick >= soonest) begin
					hit = '0;
					for (int i = 0; i < SLOTS; i++) begin
						if (arm_at[i] <= tick) begin
							arm_at[i] = NEVER_CYCLE;
							hit[i] = 1'b1;
						end
					end
					soonest = earliest_armed();
					n = $countones(hit);
					k = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (hit[i]) begin
							queue_result(1'b1, 3'(i), arm_code[i], k == n - 1);
							k++;
						end
					end
				end
			end
			default: ;
		endcase
		if (n == 0)
			queue_result(1'b0, 3'd0, 8'd0, 1'b1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		evt_t want;
		if (!arst_n) begin
			tick    = 64'd0;
			soonest = NEVER_CYCLE;
			for (int i = 0; i < SLOTS; i++) begin
				arm_at[i]   = NEVER_CYCLE;
				arm_code[i] = 8'd0;
			end
			expected_evts.delete();
		end else begin
			if (evt_valid === 1'b1 && evt_stall === 1'b0) begin
				evts_seen++;
				if (evt.fired === 1'b1)
					fires_seen++;
				if (expected_evts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected f=%0d s=%0d h=%02h clk=%h due=%h l=%0d",
							$realtime, evt.fired, evt.fired_slot, evt.fired_handler,
							evt.clock_now, evt.next_due, evt.last);
				end else begin
					want = expected_evts.pop_front();
					if (evt.fired !== want.fired || evt.fired_slot !== want.fired_slot ||
							evt.fired_handler !== want.fired_handler ||
							evt.clock_now !== want.clock_now ||
							evt.next_due !== want.next_due || evt.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: event mismatch", $realtime);
							$display("  want f=%0d s=%0d h=%02h clk=%h due=%h l=%0d",
								want.fired, want.fired_slot, want.fired_handler,
								want.clock_now, want.next_due, want.last);
							$display("  got  f=%0d s=%0d h=%02h clk=%h due=%h l=%0d",
								evt.fired, evt.fired_slot, evt.fired_handler,
								evt.clock_now, evt.next_due, evt.last);
						end
					end
				end
			end
			if (cmd_valid === 1'b1 && cmd_stall === 1'b0) begin
				cmds_seen++;
				compute_events(cmd);
			end
		end
		outstanding = expected_evts.size();
	end

endmodule

// ===== verif/slot_event_scheduler_tb.sv =====
`timescale 1ns / 1ps

module slot_event_scheduler_tb;
	import ses_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 170;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;

	int fail_count;
	int outstanding;
	int cmds_seen;
	int evts_seen;
	int fires_seen;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_req;
	int hold_ack;
	int hold_left;

	slot_event_scheduler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	slot_event_scheduler_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.evt_valid   (evt_valid),
		.evt_stall   (evt_stall),
		.evt         (evt),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.cmds_seen   (cmds_seen),
		.evts_seen   (evts_seen),
		.fires_seen  (fires_seen)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("slot_event_scheduler_tb NOT OK");
		$finish;
	end

	// Receiver: random stall, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			evt_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			evt_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_ack  <= hold_req;
		end else begin
			evt_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic cmd_t mk(input logic [1:0] op, input logic [2:0] slot,
			input logic [31:0] delta, input logic [7:0] code);
		cmd_t c;
		c.operation    = op;
		c.slot_id      = slot;
		c.delta        = delta;
		c.handler_code = code;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		int r;
		int pick;
		logic [1:0] op;
		logic [31:0] delta;
		r = $urandom_range(99);
		if (r < 40)
			op = OP_SCHEDULE;
		else if (r < 55)
			op = OP_CANCEL;
		else if (r < 95)
			op = OP_ADVANCE;
		else
			op = OP_NOP;
		// keep most deltas short so slots actually fire
		pick = $urandom_range(9);
		if (pick < 7)
			delta = $urandom_range(12);
		else if (pick == 7)
			delta = $urandom_range(40);
		else
			delta = $urandom;
		return mk(op, 3'($urandom_range(7)), delta, 8'($urandom_range(255)));
	endfunction

	// Offer one command and hold it until the transfer completes
	task automatic send(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = '0;
		evt_stall      = 1'b0;
		hold_req       = 0;
		hold_ack       = 0;
		hold_left      = 0;
		send_idle_pct  = 9;
		recv_stall_pct = 81;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send(mk(OP_ADVANCE, 3'd0, 32'd0, 8'd0));
		send(mk(OP_SCHEDULE, 3'd0, 32'd0, 8'h00));
		send(mk(OP_SCHEDULE, 3'd7, 32'd1, 8'hFF));
		send(mk(OP_SCHEDULE, 3'd3, 32'hFFFF_FFFF, 8'hA5));
		send(mk(OP_NOP, 3'd5, 32'h5A5A_5A5A, 8'h3C));
		// two slots due on the same tick
		send(mk(OP_ADVANCE, 3'd0, 32'd0, 8'd0));
		send(mk(OP_CANCEL, 3'd3, 32'd0, 8'd0));
		send(mk(OP_CANCEL, 3'd5, 32'd0, 8'd0));
		// overwrite an armed slot before it is due
		send(mk(OP_SCHEDULE, 3'd4, 32'd3, 8'h11));
		send(mk(OP_SCHEDULE, 3'd4, 32'd1, 8'h22));
		send(mk(OP_ADVANCE, 3'd0, 32'd0, 8'd0));
		// every slot due together
		for (int i = 0; i < 8; i++)
			send(mk(OP_SCHEDULE, 3'(i), 32'd2, 8'(8'h80 + i)));
		send(mk(OP_ADVANCE, 3'd0, 32'd0, 8'd0));
		send(mk(OP_ADVANCE, 3'd0, 32'd0, 8'd0));
		send(mk(OP_SCHEDULE, 3'd2, 32'h8000_0000, 8'h7F));
		send(mk(OP_ADVANCE, 3'd7, 32'hFFFF_FFFF, 8'hFF));

		for (int n = 0; n < PHASE_ITEMS; n++)
			send(random_cmd());

		send_idle_pct  = 81;
		recv_stall_pct = 9;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send(random_cmd());

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// hold the result side off while commands keep coming
		hold_req = hold_req + 1;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send(random_cmd());
		cmd_valid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d commands under three stall patterns and one long hold;",
			cmds_seen);
		$display("%0d events checked, %0d of them fired slots, %0d failures",
			evts_seen, fires_seen, fail_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("slot_event_scheduler_tb OK");
		end else begin
			$display("slot_event_scheduler_tb NOT OK");
		end
		$finish;
	end

endmodule
